>>> rtl/dcfa_pkg.sv
`timescale 1ns / 1ps

package dcfa_pkg;

    localparam int unsigned DEF_LOC_WIDTH = 32;
    localparam int unsigned DEF_REG_WIDTH = 16;
    localparam int unsigned VAL_W         = 32;
    localparam int unsigned CFG_ADDR_W    = 3;
    localparam int unsigned CFG_DATA_W    = 32;

    localparam logic REG_IDX_CODE_ALIGN = 1'b0;
    localparam logic REG_IDX_DATA_ALIGN = 1'b1;

    localparam logic [7:0] CODE_ALIGN_RESET = 8'h01;
    localparam logic [7:0] DATA_ALIGN_RESET = 8'hFC;

    localparam logic [2:0] OP_START          = 3'd0;
    localparam logic [2:0] OP_DEF_CFA        = 3'd1;
    localparam logic [2:0] OP_DEF_CFA_REG    = 3'd2;
    localparam logic [2:0] OP_DEF_CFA_OFFSET = 3'd3;
    localparam logic [2:0] OP_ADJUST_OFFSET  = 3'd4;
    localparam logic [2:0] OP_OFFSET         = 3'd5;
    localparam logic [2:0] OP_REGISTER       = 3'd6;
    localparam logic [2:0] OP_END            = 3'd7;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_NO_PROC = 2'd1;
    localparam logic [1:0] ERR_OPEN    = 2'd2;
    localparam logic [1:0] ERR_OPERAND = 2'd3;

    localparam logic [7:0] DW_CFA_ADVANCE_LOC   = 8'h40;
    localparam logic [7:0] DW_CFA_ADVANCE_LOC1  = 8'h02;
    localparam logic [7:0] DW_CFA_ADVANCE_LOC2  = 8'h03;
    localparam logic [7:0] DW_CFA_ADVANCE_LOC4  = 8'h04;
    localparam logic [7:0] DW_CFA_OFFSET_EXT    = 8'h05;
    localparam logic [7:0] DW_CFA_REGISTER      = 8'h09;
    localparam logic [7:0] DW_CFA_DEF_CFA       = 8'h0C;
    localparam logic [7:0] DW_CFA_DEF_CFA_REG   = 8'h0D;
    localparam logic [7:0] DW_CFA_DEF_CFA_OFF   = 8'h0E;
    localparam logic [7:0] DW_CFA_OFFSET        = 8'h80;

    localparam logic [31:0] SHORT_LIMIT = 32'h0000_003F;
    localparam logic [31:0] BYTE_LIMIT  = 32'h0000_00FF;
    localparam logic [31:0] HALF_LIMIT  = 32'h0000_FFFF;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ODIV,
        ST_AGO,
        ST_ADIV,
        ST_PREP,
        ST_ADV_OPC,
        ST_ADV_DATA,
        ST_OPC,
        ST_U1,
        ST_U2,
        ST_ERR
    } state_t;

endpackage

>>> rtl/dwarf_cfa_instruction_encoder_core.sv
`timescale 1ns / 1ps

// Encodes call-frame directives into DWARF call-frame instruction bytes, one byte
// per output transaction, with m_last_byte on the final byte of each directive;
// start and end directives emit no bytes unless they fail. A directive is taken
// only while the block is idle; it then runs through one shared restoring divider
// that produces one quotient bit per cycle, first for the factored offset of an
// offset directive and then for the location advance when the location moved.
// Bytes follow at one per cycle while the output side accepts them. Errors give a
// single zero byte with the error code and leave the state untouched.
// code_alignment sits at address 0, data_alignment at 4.

module dwarf_cfa_instruction_encoder_core #(
    parameter int unsigned LOC_WIDTH = dcfa_pkg::DEF_LOC_WIDTH,
    parameter int unsigned REG_WIDTH = dcfa_pkg::DEF_REG_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_op,
    input  logic [LOC_WIDTH-1:0]                s_location,
    input  logic [REG_WIDTH-1:0]                s_reg_first,
    input  logic [REG_WIDTH-1:0]                s_reg_second,
    input  logic signed [31:0]                  s_amount,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_out_byte,
    output logic                                m_last_byte,
    output logic [1:0]                          m_error_code,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dcfa_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [dcfa_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [dcfa_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import dcfa_pkg::*;

    localparam int unsigned DIV_W = (LOC_WIDTH > VAL_W) ? LOC_WIDTH : VAL_W;

    state_t state_reg, state_next;

    logic [2:0]           op_reg, op_next;
    logic [LOC_WIDTH-1:0] loc_reg, loc_next;
    logic [REG_WIDTH-1:0] r1_reg, r1_next;
    logic [REG_WIDTH-1:0] r2_reg, r2_next;
    logic [31:0]          amt_reg, amt_next;

    logic                 open_reg, open_next;
    logic [LOC_WIDTH-1:0] last_loc_reg, last_loc_next;
    logic [31:0]          fo_reg, fo_next;

    logic [31:0]          operand_reg, operand_next;
    logic [1:0]           err_reg, err_next;
    logic                 adv_flag_reg, adv_flag_next;
    logic [7:0]           adv_opc_reg, adv_opc_next;
    logic [31:0]          adv_data_reg, adv_data_next;
    logic [2:0]           adv_cnt_reg, adv_cnt_next;
    logic [7:0]           opc_reg, opc_next;
    logic [31:0]          u1_reg, u1_next;
    logic [31:0]          u2_reg, u2_next;
    logic                 has_u2_reg, has_u2_next;

    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 last_reg, last_next;
    logic [1:0]           out_err_reg, out_err_next;

    logic [7:0]           code_factor;
    logic [7:0]           data_factor;
    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [7:0]           div_divisor;
    logic [DIV_W-1:0]     div_quo;
    div_status_t          div_status;

    logic                 out_free;
    logic [32:0]          adj_sum;
    logic                 chk_fail;
    logic [1:0]           chk_code;
    logic [31:0]          amt_mag;
    logic [7:0]           da_mag;
    logic                 off_bad;
    logic                 loc_moved;
    logic [LOC_WIDTH-1:0] loc_delta;
    logic [7:0]           ca_eff;
    logic                 u1_end;
    logic                 u2_end;

    dcfa_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .code_factor (code_factor),
        .data_factor (data_factor)
    );

    dcfa_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .status   (div_status)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign adj_sum   = {1'b0, fo_reg} + {amt_reg[31], amt_reg};
    assign amt_mag   = amt_reg[31] ? (~amt_reg + 32'd1) : amt_reg;
    assign da_mag    = data_factor[7] ? (~data_factor + 8'd1) : data_factor;
    assign off_bad   = (div_quo != '0) && (amt_reg[31] ^ data_factor[7]);
    assign loc_moved = (loc_reg != last_loc_reg);
    assign loc_delta = loc_reg - last_loc_reg;
    assign ca_eff    = (code_factor == 8'd0) ? 8'd1 : code_factor;
    assign u1_end    = (u1_reg[31:7] == 25'd0);
    assign u2_end    = (u2_reg[31:7] == 25'd0);

    always_comb begin
        chk_fail = 1'b0;
        chk_code = ERR_NONE;
        priority if (op_reg == OP_START) begin
            chk_fail = open_reg;
            chk_code = ERR_OPEN;
        end else if (op_reg == OP_END) begin
            chk_fail = !open_reg;
            chk_code = ERR_NO_PROC;
        end else if (!open_reg) begin
            chk_fail = 1'b1;
            chk_code = ERR_NO_PROC;
        end else if (op_reg == OP_DEF_CFA || op_reg == OP_DEF_CFA_OFFSET) begin
            chk_fail = amt_reg[31];
            chk_code = ERR_OPERAND;
        end else if (op_reg == OP_ADJUST_OFFSET) begin
            chk_fail = adj_sum[32] | adj_sum[31];
            chk_code = ERR_OPERAND;
        end else if (op_reg == OP_OFFSET) begin
            chk_fail = (data_factor == 8'd0);
            chk_code = ERR_OPERAND;
        end else begin
            chk_fail = 1'b0;
            chk_code = ERR_NONE;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                priority if (chk_fail) begin
                    state_next = ST_ERR;
                end else if (op_reg == OP_START || op_reg == OP_END) begin
                    state_next = ST_IDLE;
                end else if (op_reg == OP_OFFSET) begin
                    state_next = ST_ODIV;
                end else begin
                    state_next = ST_AGO;
                end
            end
            ST_ODIV: begin
                if (div_status.done) state_next = off_bad ? ST_ERR : ST_AGO;
            end
            ST_AGO: begin
                state_next = loc_moved ? ST_ADIV : ST_PREP;
            end
            ST_ADIV: begin
                if (div_status.done) state_next = ST_PREP;
            end
            ST_PREP: begin
                state_next = adv_flag_reg ? ST_ADV_OPC : ST_OPC;
            end
            ST_ADV_OPC: begin
                if (out_free) state_next = (adv_cnt_reg == 3'd0) ? ST_OPC : ST_ADV_DATA;
            end
            ST_ADV_DATA: begin
                if (out_free && adv_cnt_reg == 3'd1) state_next = ST_OPC;
            end
            ST_OPC: begin
                if (out_free) state_next = ST_U1;
            end
            ST_U1: begin
                if (out_free && u1_end) state_next = has_u2_reg ? ST_U2 : ST_IDLE;
            end
            ST_U2: begin
                if (out_free && u2_end) state_next = ST_IDLE;
            end
            ST_ERR: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op_next       = op_reg;
        loc_next      = loc_reg;
        r1_next       = r1_reg;
        r2_next       = r2_reg;
        amt_next      = amt_reg;
        open_next     = open_reg;
        last_loc_next = last_loc_reg;
        fo_next       = fo_reg;
        operand_next  = operand_reg;
        err_next      = err_reg;
        adv_flag_next = adv_flag_reg;
        adv_opc_next  = adv_opc_reg;
        adv_data_next = adv_data_reg;
        adv_cnt_next  = adv_cnt_reg;
        opc_next      = opc_reg;
        u1_next       = u1_reg;
        u2_next       = u2_reg;
        has_u2_next   = has_u2_reg;
        m_valid_next  = m_valid_reg & ~m_ready;
        out_byte_next = out_byte_reg;
        last_next     = last_reg;
        out_err_next  = out_err_reg;
        div_start     = 1'b0;
        div_dividend  = '0;
        div_divisor   = 8'd1;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next  = s_op;
                    loc_next = s_location;
                    r1_next  = s_reg_first;
                    r2_next  = s_reg_second;
                    amt_next = s_amount;
                end
            end
            ST_CHECK: begin
                adv_flag_next = 1'b0;
                err_next      = chk_code;
                if (!chk_fail) begin
                    if (op_reg == OP_START) begin
                        open_next     = 1'b1;
                        last_loc_next = loc_reg;
                        fo_next       = 32'd0;
                    end
                    if (op_reg == OP_END) open_next = 1'b0;
                    if (op_reg == OP_DEF_CFA || op_reg == OP_DEF_CFA_OFFSET) begin
                        operand_next = amt_reg;
                    end
                    if (op_reg == OP_ADJUST_OFFSET) operand_next = adj_sum[31:0];
                    if (op_reg == OP_OFFSET) begin
                        div_start    = 1'b1;
                        div_dividend = DIV_W'(amt_mag);
                        div_divisor  = da_mag;
                    end
                end
            end
            ST_ODIV: begin
                if (div_status.done) begin
                    err_next     = ERR_OPERAND;
                    operand_next = div_quo[31:0];
                end
            end
            ST_AGO: begin
                if (loc_moved) begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(loc_delta);
                    div_divisor  = ca_eff;
                end
            end
            ST_ADIV: begin
                if (div_status.done) begin
                    adv_flag_next = 1'b1;
                    adv_data_next = div_quo[31:0];
                    priority if (div_quo <= DIV_W'(SHORT_LIMIT)) begin
                        adv_opc_next = DW_CFA_ADVANCE_LOC | {2'b00, div_quo[5:0]};
                        adv_cnt_next = 3'd0;
                    end else if (div_quo <= DIV_W'(BYTE_LIMIT)) begin
                        adv_opc_next = DW_CFA_ADVANCE_LOC1;
                        adv_cnt_next = 3'd1;
                    end else if (div_quo <= DIV_W'(HALF_LIMIT)) begin
                        adv_opc_next = DW_CFA_ADVANCE_LOC2;
                        adv_cnt_next = 3'd2;
                    end else begin
                        adv_opc_next = DW_CFA_ADVANCE_LOC4;
                        adv_cnt_next = 3'd4;
                    end
                end
            end
            ST_PREP: begin
                last_loc_next = loc_reg;
                has_u2_next   = 1'b0;
                u2_next       = 32'd0;
                unique case (op_reg)
                    OP_DEF_CFA: begin
                        opc_next    = DW_CFA_DEF_CFA;
                        u1_next     = 32'(r1_reg);
                        u2_next     = operand_reg;
                        has_u2_next = 1'b1;
                        fo_next     = operand_reg;
                    end
                    OP_DEF_CFA_REG: begin
                        opc_next = DW_CFA_DEF_CFA_REG;
                        u1_next  = 32'(r1_reg);
                    end
                    OP_DEF_CFA_OFFSET, OP_ADJUST_OFFSET: begin
                        opc_next = DW_CFA_DEF_CFA_OFF;
                        u1_next  = operand_reg;
                        fo_next  = operand_reg;
                    end
                    OP_OFFSET: begin
                        if (32'(r1_reg) <= SHORT_LIMIT) begin
                            opc_next = DW_CFA_OFFSET | {2'b00, r1_reg[5:0]};
                            u1_next  = operand_reg;
                        end else begin
                            opc_next    = DW_CFA_OFFSET_EXT;
                            u1_next     = 32'(r1_reg);
                            u2_next     = operand_reg;
                            has_u2_next = 1'b1;
                        end
                    end
                    default: begin
                        opc_next    = DW_CFA_REGISTER;
                        u1_next     = 32'(r1_reg);
                        u2_next     = 32'(r2_reg);
                        has_u2_next = 1'b1;
                    end
                endcase
            end
            ST_ADV_OPC: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_byte_next = adv_opc_reg;
                    last_next     = 1'b0;
                    out_err_next  = ERR_NONE;
                end
            end
            ST_ADV_DATA: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_byte_next = adv_data_reg[7:0];
                    last_next     = 1'b0;
                    out_err_next  = ERR_NONE;
                    adv_data_next = {8'd0, adv_data_reg[31:8]};
                    adv_cnt_next  = adv_cnt_reg - 3'd1;
                end
            end
            ST_OPC: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_byte_next = opc_reg;
                    last_next     = 1'b0;
                    out_err_next  = ERR_NONE;
                end
            end
            ST_U1: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_byte_next = {~u1_end, u1_reg[6:0]};
                    last_next     = u1_end & ~has_u2_reg;
                    out_err_next  = ERR_NONE;
                    u1_next       = {7'd0, u1_reg[31:7]};
                end
            end
            ST_U2: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_byte_next = {~u2_end, u2_reg[6:0]};
                    last_next     = u2_end;
                    out_err_next  = ERR_NONE;
                    u2_next       = {7'd0, u2_reg[31:7]};
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_byte_next = 8'd0;
                    last_next     = 1'b1;
                    out_err_next  = err_reg;
                end
            end
            default: begin
                m_valid_next = m_valid_reg & ~m_ready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            open_reg     <= 1'b0;
            last_loc_reg <= '0;
            fo_reg       <= 32'd0;
            m_valid_reg  <= 1'b0;
            adv_flag_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            open_reg     <= open_next;
            last_loc_reg <= last_loc_next;
            fo_reg       <= fo_next;
            m_valid_reg  <= m_valid_next;
            adv_flag_reg <= adv_flag_next;
        end
        op_reg       <= op_next;
        loc_reg      <= loc_next;
        r1_reg       <= r1_next;
        r2_reg       <= r2_next;
        amt_reg      <= amt_next;
        operand_reg  <= operand_next;
        err_reg      <= err_next;
        adv_opc_reg  <= adv_opc_next;
        adv_data_reg <= adv_data_next;
        adv_cnt_reg  <= adv_cnt_next;
        opc_reg      <= opc_next;
        u1_reg       <= u1_next;
        u2_reg       <= u2_next;
        has_u2_reg   <= has_u2_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        out_err_reg  <= out_err_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_last_byte  = last_reg;
    assign m_error_code = out_err_reg;

endmodule

>>> rtl/dcfa_div.sv
`timescale 1ns / 1ps

module dcfa_div #(
    parameter int unsigned DIV_W = dcfa_pkg::VAL_W
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [DIV_W-1:0]          dividend,
    input  logic [7:0]                divisor,
    output logic [DIV_W-1:0]          quotient,
    output dcfa_pkg::div_status_t     status
);
    import dcfa_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [7:0]       rem_reg, rem_next;
    logic [7:0]       dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [8:0]       trial;
    logic             ge;

    always_comb begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = 8'd0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? 8'(trial - {1'b0, dvs_reg}) : trial[7:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> rtl/dcfa_regs.sv
`timescale 1ns / 1ps

module dcfa_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dcfa_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [dcfa_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [dcfa_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [7:0]                          code_factor,
    output logic [7:0]                          data_factor
);
    import dcfa_pkg::*;

    logic [7:0] code_factor_reg, code_factor_next;
    logic [7:0] data_factor_reg, data_factor_next;
    logic       wr_en;

    assign wr_en = psel & penable & pwrite;

    always_comb begin
        code_factor_next = code_factor_reg;
        data_factor_next = data_factor_reg;
        if (wr_en) begin
            if (paddr[2] == REG_IDX_CODE_ALIGN) begin
                code_factor_next = pwdata[7:0];
            end else begin
                data_factor_next = pwdata[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_factor_reg <= CODE_ALIGN_RESET;
            data_factor_reg <= DATA_ALIGN_RESET;
        end else begin
            code_factor_reg <= code_factor_next;
            data_factor_reg <= data_factor_next;
        end
    end

    always_comb begin
        if (paddr[2] == REG_IDX_CODE_ALIGN) begin
            prdata = CFG_DATA_W'(code_factor_reg);
        end else begin
            prdata = CFG_DATA_W'(data_factor_reg);
        end
    end

    assign pready      = 1'b1;
    assign code_factor = code_factor_reg;
    assign data_factor = data_factor_reg;

endmodule
